@@ rtl/ordered_list_with_remove_by_value_assert.svh @@
// assertion macros used by the checker file of the ordered list
`ifndef ORDERED_LIST_WITH_REMOVE_BY_VALUE_ASSERT_SVH
`define ORDERED_LIST_WITH_REMOVE_BY_VALUE_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define OLRV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("olrv check failed");

// next-cycle implication, disabled while reset is held
`define OLRV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("olrv check failed");

`endif

@@ rtl/olrv_pkg.sv @@
// package with the item types, codes and cell control of the ordered list
`timescale 1ns / 1ps
package olrv_pkg;

    localparam int VALUE_W = 32;
    localparam int OPCODE_W = 3;
    localparam int POS_W = 4;
    localparam int ECNT_W = 5;

    typedef logic signed [VALUE_W-1:0] t_value;

    typedef enum logic [OPCODE_W-1:0] {
        OP_APPEND       = 3'd0,
        OP_REMOVE_FIRST = 3'd1,
        OP_REMOVE_LAST  = 3'd2,
        OP_REMOVE_VALUE = 3'd3,
        OP_READOUT      = 3'd4,
        OP_CLEAR        = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        t_value              value;
    } t_in_item;

    typedef struct packed {
        t_status           status;
        t_value            item_value;
        logic [POS_W-1:0]  position;
        logic [ECNT_W-1:0] entry_count;
        logic              last;
    } t_out_item;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_POP_FRONT,
        CELL_DROP_MATCH,
        CELL_ROTATE
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd cmd;
        logic      occupied;
        logic      is_tail;
        logic      is_last;
    } t_cell_ctl;

endpackage

@@ rtl/olrv_cell.sv @@
// one storage cell of the list chain: holds one entry, compares and shifts
`timescale 1ns / 1ps
module olrv_cell (
    input  logic               i_clk,
    input  olrv_pkg::t_cell_ctl i_ctl,
    input  olrv_pkg::t_value   i_key,
    input  olrv_pkg::t_value   i_bcast,
    input  olrv_pkg::t_value   i_next,
    input  logic               i_seen,
    input  olrv_pkg::t_value   i_tap,
    output olrv_pkg::t_value   o_value,
    output logic               o_seen,
    output olrv_pkg::t_value   o_tap
);
    import olrv_pkg::*;

    t_value r_value;
    t_value n_value;
    logic   hit;

    assign hit     = i_ctl.occupied && (r_value == i_key);
    assign o_seen  = i_seen | hit;
    assign o_tap   = i_tap | (i_ctl.is_last ? r_value : '0);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        case (i_ctl.cmd)
            CELL_APPEND: begin
                if (i_ctl.is_tail) begin
                    n_value = i_bcast;
                end
            end
            CELL_POP_FRONT: begin
                n_value = i_next;
            end
            CELL_DROP_MATCH: begin
                // shift down once a match sits here or below
                if (o_seen) begin
                    n_value = i_next;
                end
            end
            CELL_ROTATE: begin
                n_value = i_ctl.is_last ? i_bcast : i_next;
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

@@ rtl/ordered_list_with_remove_by_value.sv @@
// top level of the ordered list: count, control and the row of cells
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+---------------------------
//  command   | start in, busy out        | i_item   (opcode, value)
//  result    | o_strobe out, no stall    | o_result (status, item_value,
//            |                           |  position, entry_count, last)
//
// every edit gives a single result on o_result in the cycle after the item
// is taken, and busy stays low so the next item may follow
// a readout of n entries keeps busy high while the cells rotate the list
// through cell 0; the results follow one per cycle, registered from each step
// reset is synchronous, active low; it clears the count, busy and the strobe
// the result side cannot stall, so each result is valid for one cycle only
`timescale 1ns / 1ps
module ordered_list_with_remove_by_value #(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  olrv_pkg::t_in_item  i_item,
    output logic                o_strobe,
    output olrv_pkg::t_out_item o_result
);
    import olrv_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    // control state
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_reading;
    logic             n_reading;
    logic [IDX_W-1:0] r_rd_pos;
    logic [IDX_W-1:0] n_rd_pos;
    logic             r_strobe;
    logic             n_strobe;
    t_out_item        r_result;
    t_out_item        n_result;

    // chain wiring
    t_value           cell_value [DEPTH];
    logic             seen_chain [DEPTH+1];
    t_value           tap_chain  [DEPTH+1];
    t_cell_cmd        cmd;
    t_value           bcast;

    logic             accept;
    logic             found;
    logic             rd_last;
    logic             not_empty;
    logic             not_full;

    assign accept    = start && !r_reading;
    assign found     = seen_chain[DEPTH];
    assign not_empty = (r_count != '0);
    assign not_full  = (r_count < CNT_W'(DEPTH));
    assign rd_last   = (CNT_W'(r_rd_pos) == r_count - CNT_W'(1));

    // the chain starts with nothing seen and nothing tapped
    assign seen_chain[0] = 1'b0;
    assign tap_chain[0]  = '0;

    // command for all cells this cycle
    always_comb begin
        cmd = CELL_HOLD;
        if (r_reading) begin
            cmd = CELL_ROTATE;
        end else if (accept) begin
            case (i_item.opcode)
                OP_APPEND:       cmd = not_full ? CELL_APPEND : CELL_HOLD;
                OP_REMOVE_FIRST: cmd = not_empty ? CELL_POP_FRONT : CELL_HOLD;
                OP_REMOVE_VALUE: cmd = CELL_DROP_MATCH;
                default:         cmd = CELL_HOLD;
            endcase
        end
    end

    // a rotation feeds the head back into the last occupied cell
    assign bcast = r_reading ? cell_value[0] : i_item.value;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_ctl ctl;
        t_value    next_val;

        assign ctl.cmd      = cmd;
        assign ctl.occupied = (CNT_W'(g) < r_count);
        assign ctl.is_tail  = (CNT_W'(g) == r_count);
        assign ctl.is_last  = (CNT_W'(g) == r_count - CNT_W'(1));

        if (g == DEPTH - 1) begin : g_end
            // nothing beyond the last cell; its shifted-in value is never read
            assign next_val = bcast;
        end else begin : g_mid
            assign next_val = cell_value[g+1];
        end

        olrv_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_key   (i_item.value),
            .i_bcast (bcast),
            .i_next  (next_val),
            .i_seen  (seen_chain[g]),
            .i_tap   (tap_chain[g]),
            .o_value (cell_value[g]),
            .o_seen  (seen_chain[g+1]),
            .o_tap   (tap_chain[g+1])
        );
    end

    // next count, readout progress and result
    always_comb begin
        n_count   = r_count;
        n_reading = r_reading;
        n_rd_pos  = r_rd_pos;
        n_strobe  = 1'b0;
        n_result  = r_result;

        if (r_reading) begin
            // readout: head of the list is the next entry in order
            n_strobe             = 1'b1;
            n_result.status      = ST_OK;
            n_result.item_value  = cell_value[0];
            n_result.position    = POS_W'(r_rd_pos);
            n_result.entry_count = ECNT_W'(r_count);
            n_result.last        = rd_last;
            n_rd_pos             = r_rd_pos + IDX_W'(1);
            if (rd_last) begin
                n_reading = 1'b0;
            end
        end else if (accept) begin
            n_result.status      = ST_OK;
            n_result.item_value  = '0;
            n_result.position    = '0;
            n_result.last        = 1'b1;
            n_strobe             = 1'b1;
            case (i_item.opcode)
                OP_APPEND: begin
                    n_result.item_value = i_item.value;
                    if (not_full) begin
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_result.status = ST_FULL;
                    end
                end
                OP_REMOVE_FIRST: begin
                    if (not_empty) begin
                        n_result.item_value = cell_value[0];
                        n_count = r_count - CNT_W'(1);
                    end else begin
                        n_result.status = ST_EMPTY;
                    end
                end
                OP_REMOVE_LAST: begin
                    if (not_empty) begin
                        n_result.item_value = tap_chain[DEPTH];
                        n_count = r_count - CNT_W'(1);
                    end else begin
                        n_result.status = ST_EMPTY;
                    end
                end
                OP_REMOVE_VALUE: begin
                    n_result.item_value = i_item.value;
                    if (found) begin
                        n_count = r_count - CNT_W'(1);
                    end else begin
                        n_result.status = ST_NOTFOUND;
                    end
                end
                OP_READOUT: begin
                    if (not_empty) begin
                        // results come from the rotation cycles
                        n_strobe  = 1'b0;
                        n_reading = 1'b1;
                        n_rd_pos  = '0;
                    end else begin
                        n_result.status = ST_EMPTY;
                    end
                end
                OP_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    // unused codes give no result
                    n_strobe = 1'b0;
                end
            endcase
            n_result.entry_count = ECNT_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_reading <= 1'b0;
            r_rd_pos  <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_reading <= n_reading;
            r_rd_pos  <= n_rd_pos;
            r_strobe  <= n_strobe;
        end
    end

    // result payload needs no reset
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign busy     = r_reading;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

@@ rtl/olrv_checker.sv @@
// port-level checker of the ordered list, bound to the top level
`timescale 1ns / 1ps
`include "ordered_list_with_remove_by_value_assert.svh"
module olrv_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input olrv_pkg::t_in_item  i_item,
    input logic                o_strobe,
    input olrv_pkg::t_out_item o_result
);
    import olrv_pkg::*;

    logic take;
    logic take_edit;
    logic take_unused;

    assign take        = start && !busy;
    assign take_edit   = take && (i_item.opcode == OP_APPEND ||
                                  i_item.opcode == OP_REMOVE_FIRST ||
                                  i_item.opcode == OP_REMOVE_LAST ||
                                  i_item.opcode == OP_REMOVE_VALUE ||
                                  i_item.opcode == OP_CLEAR);
    assign take_unused = take && i_item.opcode != OP_APPEND &&
                         i_item.opcode != OP_REMOVE_FIRST &&
                         i_item.opcode != OP_REMOVE_LAST &&
                         i_item.opcode != OP_REMOVE_VALUE &&
                         i_item.opcode != OP_READOUT &&
                         i_item.opcode != OP_CLEAR;

    // an edit answers with exactly one final result in the next cycle
    `OLRV_ASSERT_NEXT(a_edit_result, i_clk, i_rst_n, take_edit, o_strobe && o_result.last)
    // unused codes produce nothing
    `OLRV_ASSERT_NEXT(a_unused_silent, i_clk, i_rst_n, take_unused, !o_strobe)
    // readout starts at position zero right after busy rises
    `OLRV_ASSERT_NEXT(a_read_first, i_clk, i_rst_n, $rose(busy), o_strobe && o_result.position == '0)
    // the final result of a readout comes with busy already released
    `OLRV_ASSERT_NOW(a_last_free, i_clk, i_rst_n, o_strobe && o_result.last, !busy)
    // a non-final result only appears inside a readout
    `OLRV_ASSERT_NOW(a_mid_busy, i_clk, i_rst_n, o_strobe && !o_result.last, busy)

endmodule

bind ordered_list_with_remove_by_value olrv_checker u_olrv_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
